// ===== rtl/sscc_pkg.sv =====
// sscc_pkg: shared widths and word types for the swept sphere / cylinder contact block
// no dependencies; imported by the root and quotient cells and by the top level
package sscc_pkg;

    localparam int TIME_FB  = 16;              // fraction bits of a contact time
    localparam int Q_W      = TIME_FB + 2;     // quotient bits, enough to show saturation
    localparam int C_W      = 32;              // coordinate width
    localparam int DIF_W    = C_W + 1;         // coordinate difference
    localparam int MAG_W    = C_W;             // magnitude of a difference
    localparam int PROD_W   = 2 * MAG_W;       // square of a magnitude
    localparam int SUM_W    = PROD_W + 1;      // sum of two squares
    localparam int HALF_W   = (SUM_W + 1) / 2; // low half of a split operand
    localparam int PP_W     = 2 * HALF_W;      // partial product
    localparam int WIDE_W   = 2 * SUM_W;       // full product of two sums
    localparam int LHS_W    = WIDE_W + 1;
    localparam int RAD_W    = LHS_W + (LHS_W % 2);
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int N_W      = ROOT_W;          // dividend magnitude
    localparam int D_W      = SUM_W;           // divisor
    localparam int DIV_W    = N_W + TIME_FB;   // dividend after scaling
    localparam int VN_W     = C_W + 3;         // vertical slab numerator, signed
    localparam int VM_W     = VN_W - 1;
    localparam int OUT_T_W  = 17;

    typedef struct packed {
        logic signed [C_W-1:0] start_x;
        logic signed [C_W-1:0] start_y;
        logic signed [C_W-1:0] start_z;
        logic signed [C_W-1:0] end_x;
        logic signed [C_W-1:0] end_y;
        logic signed [C_W-1:0] end_z;
        logic signed [C_W-1:0] sphere_radius;
        logic signed [C_W-1:0] base_x;
        logic signed [C_W-1:0] base_y;
        logic signed [C_W-1:0] base_z;
        logic signed [C_W-1:0] cylinder_radius;
        logic signed [C_W-1:0] cylinder_height;
    } t_in_word;

    typedef struct packed {
        logic               hit;
        logic [OUT_T_W-1:0] enter_time;
    } t_out_word;

endpackage

// ===== rtl/swept_sphere_cylinder_contact.sv =====
// swept_sphere_cylinder_contact: swept sphere against upright cylinder, first contact time
// depends on sscc_pkg, sscc_sqrt_cell, sscc_div_cell
//
//   channel   valid     stall     word
//   query     i_valid   o_stall   i_data (t_in_word)
//   result    o_valid   i_stall   o_data (t_out_word)
//
// one word enters per cycle while o_stall is low; 12 fixed stages, 66 root cells, 18 quotient cells
// the root cell row and the four quotient rows set the depth; while the pipe moves, each word moves one cell a cycle
// reset clears only the valid bits; there is no state between words
// the whole pipe moves unless the skid word behind the output register is full; o_stall
// is that skid flag, so a word is still taken while a result waits
module swept_sphere_cylinder_contact (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  sscc_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output sscc_pkg::t_out_word  o_data
);
    import sscc_pkg::*;

    localparam int PR_W = ROOT_W + 1;

    typedef logic signed [Q_W:0] t_time;
    localparam t_time T_NEG  = '1;
    localparam t_time T_ZERO = '0;
    localparam t_time T_ONE  = t_time'(1 << TIME_FB);
    localparam logic [Q_W-1:0] T_CAP = Q_W'((1 << TIME_FB) + 1);

    typedef struct packed {
        logic [VM_W-1:0]  lo_mag;
        logic [VM_W-1:0]  hi_mag;
        logic [MAG_W-1:0] den_mag;
        logic             lo_zero;
        logic             lo_tneg;
        logic             hi_zero;
        logic             hi_tneg;
        logic             v_en;
        logic             v_miss;
    } t_vert;

    typedef struct packed {
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] pos;
        logic [SUM_W-1:0] neg;
        logic             a_zero;
        logic             q_gt;
        logic             h_miss;
        t_vert            vert;
    } t_side;

    typedef struct packed {
        logic a_zero;
        logic q_gt;
        logic h_miss;
        logic he_neg;
        logic hl_neg;
        logic lo_zero;
        logic lo_tneg;
        logic hi_zero;
        logic hi_tneg;
        logic v_en;
        logic v_miss;
    } t_fin;

    function automatic logic [MAG_W-1:0] f_mag(input logic signed [DIF_W-1:0] v);
        f_mag = MAG_W'(v[DIF_W-1] ? -v : v);
    endfunction

    function automatic t_time f_cap(input logic [Q_W-1:0] q);
        f_cap = (q > T_CAP) ? t_time'({1'b0, T_CAP}) : t_time'({1'b0, q});
    endfunction

    // stage 1: differences
    logic                    r1_v;
    logic signed [DIF_W-1:0] r1_rx, r1_ry, r1_rz, r1_dx, r1_dy, r1_dz;
    logic signed [C_W-1:0]   r1_rad, r1_crad, r1_hgt;

    // stage 2: magnitudes, vertical slab terms
    logic                    r2_v;
    logic [MAG_W-1:0]        r2_ux, r2_uz, r2_vx, r2_vz, r2_reach;
    logic                    r2_sxd, r2_szd;
    t_vert                   r2_vert;
    logic signed [VN_W-1:0]  n2_lo, n2_hi;
    t_vert                   n2_vert;

    // stage 3: squares and cross products
    logic                    r3_v;
    logic [PROD_W-1:0]       r3_pvx, r3_pvz, r3_pux, r3_puz, r3_pr, r3_pxx, r3_pzz;
    logic                    r3_sxd, r3_szd;
    t_vert                   r3_vert;

    // stage 4: sums
    logic                    r4_v;
    logic [SUM_W-1:0]        r4_a, r4_q, r4_pos, r4_neg;
    logic [PROD_W-1:0]       r4_r2;
    t_vert                   r4_vert;
    logic [SUM_W-1:0]        n4_pos, n4_neg;

    // stages 5 to 9: quadratic terms
    logic                    r5_v, r6_v, r7_v, r8_v, r9_v;
    logic [SUM_W-1:0]        r5_bm, r5_q;
    logic [PROD_W-1:0]       r5_r2;
    t_side                   r5_side, r6_side, r7_side, r8_side, r9_side;
    t_side                   n9_side;
    logic [SUM_W-1:0]        n6_x [0:2];
    logic [SUM_W-1:0]        n6_y [0:2];
    logic [PP_W-1:0]         n6_pp [0:2][0:3];
    logic [PP_W-1:0]         r6_pp [0:2][0:3];
    logic [WIDE_W-1:0]       r7_prod [0:2];
    logic [LHS_W-1:0]        r8_lhs, r8_rhs;
    logic [RAD_W-1:0]        r9_disc;

    // root cell row
    logic [RAD_W-1:0]        c_rad  [0:ROOT_W];
    logic [REM_W-1:0]        c_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]       c_root [0:ROOT_W];
    logic                    r_sq_v    [0:ROOT_W-1];
    t_side                   r_sq_side [0:ROOT_W-1];

    // root sums and dividends
    logic                    r_p1_v, r_p2_v;
    logic [PR_W-1:0]         r_p1_pr, r_p1_nr;
    t_side                   r_p1_side;
    logic [N_W-1:0]          r_p2_n [0:3];
    logic [D_W-1:0]          r_p2_d [0:3];
    t_fin                    r_p2_fin;

    // quotient cell rows: entry time, leave time, slab bottom, slab top
    logic [DIV_W-1:0]        c_drem [0:3][0:Q_W];
    logic [DIV_W-1:0]        c_dsh  [0:3][0:Q_W];
    logic [Q_W-1:0]          c_q    [0:3][0:Q_W];
    logic                    r_dv_v   [0:Q_W-1];
    t_fin                    r_dv_fin [0:Q_W-1];

    // output register and skid word
    logic                    r_ov, r_skid_v;
    t_out_word               r_od, r_skid_d;
    t_out_word               n_out;

    logic w_en;
    assign w_en = !r_skid_v;

    always_comb begin
        n2_lo = -VN_W'(r1_rad) - VN_W'(r1_ry);
        n2_hi = VN_W'(r1_hgt) + VN_W'(r1_rad) - VN_W'(r1_ry);
        n2_vert.lo_mag  = VM_W'(n2_lo[VN_W-1] ? -n2_lo : n2_lo);
        n2_vert.hi_mag  = VM_W'(n2_hi[VN_W-1] ? -n2_hi : n2_hi);
        n2_vert.den_mag = f_mag(r1_dy);
        n2_vert.lo_zero = n2_lo == '0;
        n2_vert.hi_zero = n2_hi == '0;
        n2_vert.lo_tneg = (n2_lo != '0) && (n2_lo[VN_W-1] != r1_dy[DIF_W-1]);
        n2_vert.hi_tneg = (n2_hi != '0) && (n2_hi[VN_W-1] != r1_dy[DIF_W-1]);
        n2_vert.v_en    = r1_dy != '0;
        // no vertical motion: centre must already sit inside the slab
        n2_vert.v_miss  = (r1_dy == '0)
                        && ((!n2_lo[VN_W-1] && n2_lo != '0) || n2_hi[VN_W-1]);
    end

    always_comb begin
        n4_pos = (r3_sxd ? SUM_W'(0) : SUM_W'(r3_pxx)) + (r3_szd ? SUM_W'(0) : SUM_W'(r3_pzz));
        n4_neg = (r3_sxd ? SUM_W'(r3_pxx) : SUM_W'(0)) + (r3_szd ? SUM_W'(r3_pzz) : SUM_W'(0));
    end

    // wide products split into a 33 bit low half and a 32 bit high half
    always_comb begin
        n6_x[0] = r5_bm;      n6_y[0] = r5_bm;
        n6_x[1] = r5_side.a;  n6_y[1] = SUM_W'(r5_r2);
        n6_x[2] = r5_side.a;  n6_y[2] = r5_q;
        for (int j = 0; j < 3; j++) begin
            n6_pp[j][0] = PP_W'(n6_x[j][HALF_W-1:0]) * PP_W'(n6_y[j][HALF_W-1:0]);
            n6_pp[j][1] = PP_W'(n6_x[j][HALF_W-1:0]) * PP_W'(n6_y[j][SUM_W-1:HALF_W]);
            n6_pp[j][2] = PP_W'(n6_x[j][SUM_W-1:HALF_W]) * PP_W'(n6_y[j][HALF_W-1:0]);
            n6_pp[j][3] = PP_W'(n6_x[j][SUM_W-1:HALF_W]) * PP_W'(n6_y[j][SUM_W-1:HALF_W]);
        end
    end

    always_comb begin
        n9_side        = r8_side;
        n9_side.h_miss = !r8_side.a_zero && (r8_lhs < r8_rhs);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_rx   <= DIF_W'(i_data.start_x) - DIF_W'(i_data.base_x);
            r1_ry   <= DIF_W'(i_data.start_y) - DIF_W'(i_data.base_y);
            r1_rz   <= DIF_W'(i_data.start_z) - DIF_W'(i_data.base_z);
            r1_dx   <= DIF_W'(i_data.end_x) - DIF_W'(i_data.start_x);
            r1_dy   <= DIF_W'(i_data.end_y) - DIF_W'(i_data.start_y);
            r1_dz   <= DIF_W'(i_data.end_z) - DIF_W'(i_data.start_z);
            r1_rad  <= i_data.sphere_radius;
            r1_crad <= i_data.cylinder_radius;
            r1_hgt  <= i_data.cylinder_height;

            r2_ux    <= f_mag(r1_rx);
            r2_uz    <= f_mag(r1_rz);
            r2_vx    <= f_mag(r1_dx);
            r2_vz    <= f_mag(r1_dz);
            // negative radii count as zero in the horizontal plane
            r2_reach <= (r1_rad[C_W-1] ? MAG_W'(0) : MAG_W'(r1_rad))
                      + (r1_crad[C_W-1] ? MAG_W'(0) : MAG_W'(r1_crad));
            r2_sxd   <= r1_rx[DIF_W-1] != r1_dx[DIF_W-1];
            r2_szd   <= r1_rz[DIF_W-1] != r1_dz[DIF_W-1];
            r2_vert  <= n2_vert;

            r3_pvx  <= PROD_W'(r2_vx) * PROD_W'(r2_vx);
            r3_pvz  <= PROD_W'(r2_vz) * PROD_W'(r2_vz);
            r3_pux  <= PROD_W'(r2_ux) * PROD_W'(r2_ux);
            r3_puz  <= PROD_W'(r2_uz) * PROD_W'(r2_uz);
            r3_pr   <= PROD_W'(r2_reach) * PROD_W'(r2_reach);
            r3_pxx  <= PROD_W'(r2_ux) * PROD_W'(r2_vx);
            r3_pzz  <= PROD_W'(r2_uz) * PROD_W'(r2_vz);
            r3_sxd  <= r2_sxd;
            r3_szd  <= r2_szd;
            r3_vert <= r2_vert;

            r4_a    <= SUM_W'(r3_pvx) + SUM_W'(r3_pvz);
            r4_q    <= SUM_W'(r3_pux) + SUM_W'(r3_puz);
            r4_r2   <= r3_pr;
            r4_pos  <= n4_pos;
            r4_neg  <= n4_neg;
            r4_vert <= r3_vert;

            r5_bm          <= (r4_pos >= r4_neg) ? r4_pos - r4_neg : r4_neg - r4_pos;
            r5_q           <= r4_q;
            r5_r2          <= r4_r2;
            r5_side.a      <= r4_a;
            r5_side.pos    <= r4_pos;
            r5_side.neg    <= r4_neg;
            r5_side.a_zero <= r4_a == '0;
            r5_side.q_gt   <= r4_q > SUM_W'(r4_r2);
            r5_side.h_miss <= 1'b0;
            r5_side.vert   <= r4_vert;

            r6_pp   <= n6_pp;
            r6_side <= r5_side;

            for (int j = 0; j < 3; j++) begin
                r7_prod[j] <= (WIDE_W'(r6_pp[j][3]) << (2 * HALF_W))
                            + ((WIDE_W'(r6_pp[j][1]) + WIDE_W'(r6_pp[j][2])) << HALF_W)
                            + WIDE_W'(r6_pp[j][0]);
            end
            r7_side <= r6_side;

            r8_lhs  <= LHS_W'(r7_prod[0]) + LHS_W'(r7_prod[1]);
            r8_rhs  <= LHS_W'(r7_prod[2]);
            r8_side <= r7_side;

            r9_disc <= RAD_W'(r8_lhs - r8_rhs);
            r9_side <= n9_side;

            r_sq_side[0] <= r9_side;
            for (int k = 1; k < ROOT_W; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end

            r_p1_pr   <= PR_W'(r_sq_side[ROOT_W-1].pos) + PR_W'(c_root[ROOT_W]);
            r_p1_nr   <= PR_W'(r_sq_side[ROOT_W-1].neg) + PR_W'(c_root[ROOT_W]);
            r_p1_side <= r_sq_side[ROOT_W-1];

            r_p2_n[0] <= N_W'(PR_W'(r_p1_side.neg) - r_p1_pr);
            r_p2_n[1] <= N_W'(r_p1_nr - PR_W'(r_p1_side.pos));
            r_p2_n[2] <= N_W'(r_p1_side.vert.lo_mag);
            r_p2_n[3] <= N_W'(r_p1_side.vert.hi_mag);
            r_p2_d[0] <= r_p1_side.a;
            r_p2_d[1] <= r_p1_side.a;
            r_p2_d[2] <= D_W'(r_p1_side.vert.den_mag);
            r_p2_d[3] <= D_W'(r_p1_side.vert.den_mag);
            r_p2_fin.a_zero  <= r_p1_side.a_zero;
            r_p2_fin.q_gt    <= r_p1_side.q_gt;
            r_p2_fin.h_miss  <= r_p1_side.h_miss;
            r_p2_fin.he_neg  <= PR_W'(r_p1_side.neg) < r_p1_pr;
            r_p2_fin.hl_neg  <= r_p1_nr < PR_W'(r_p1_side.pos);
            r_p2_fin.lo_zero <= r_p1_side.vert.lo_zero;
            r_p2_fin.lo_tneg <= r_p1_side.vert.lo_tneg;
            r_p2_fin.hi_zero <= r_p1_side.vert.hi_zero;
            r_p2_fin.hi_tneg <= r_p1_side.vert.hi_tneg;
            r_p2_fin.v_en    <= r_p1_side.vert.v_en;
            r_p2_fin.v_miss  <= r_p1_side.vert.v_miss;

            r_dv_fin[0] <= r_p2_fin;
            for (int k = 1; k < Q_W; k++) begin
                r_dv_fin[k] <= r_dv_fin[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r5_v   <= 1'b0;
            r6_v   <= 1'b0;
            r7_v   <= 1'b0;
            r8_v   <= 1'b0;
            r9_v   <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            for (int k = 0; k < ROOT_W; k++) begin
                r_sq_v[k] <= 1'b0;
            end
            for (int k = 0; k < Q_W; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r1_v      <= i_valid;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r4_v      <= r3_v;
            r5_v      <= r4_v;
            r6_v      <= r5_v;
            r7_v      <= r6_v;
            r8_v      <= r7_v;
            r9_v      <= r8_v;
            r_sq_v[0] <= r9_v;
            for (int k = 1; k < ROOT_W; k++) begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
            r_p1_v    <= r_sq_v[ROOT_W-1];
            r_p2_v    <= r_p1_v;
            r_dv_v[0] <= r_p2_v;
            for (int k = 1; k < Q_W; k++) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end
    end

    assign c_rad[0]  = r9_disc;
    assign c_rem[0]  = '0;
    assign c_root[0] = '0;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
        sscc_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (c_rad[k]),
            .i_rem  (c_rem[k]),
            .i_root (c_root[k]),
            .o_rad  (c_rad[k+1]),
            .o_rem  (c_rem[k+1]),
            .o_root (c_root[k+1])
        );
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        // dividend scaled by the time fraction, divisor aligned to the top quotient bit
        assign c_drem[l][0] = {r_p2_n[l], {TIME_FB{1'b0}}};
        assign c_dsh[l][0]  = DIV_W'({r_p2_d[l], {(Q_W-1){1'b0}}});
        assign c_q[l][0]    = '0;
        for (genvar k = 0; k < Q_W; k++) begin : g_dv
            sscc_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_rem (c_drem[l][k]),
                .i_dsh (c_dsh[l][k]),
                .i_q   (c_q[l][k]),
                .o_rem (c_drem[l][k+1]),
                .o_dsh (c_dsh[l][k+1]),
                .o_q   (c_q[l][k+1])
            );
        end
    end

    // combine the time windows
    always_comb begin
        t_fin  f;
        t_time he, hl, lo, hi, mn, mx, enter, leave;
        logic  miss;
        f     = r_dv_fin[Q_W-1];
        he    = f.he_neg ? T_NEG : f_cap(c_q[0][Q_W]);
        hl    = f.hl_neg ? T_NEG : f_cap(c_q[1][Q_W]);
        lo    = f.lo_zero ? T_ZERO : (f.lo_tneg ? T_NEG : f_cap(c_q[2][Q_W]));
        hi    = f.hi_zero ? T_ZERO : (f.hi_tneg ? T_NEG : f_cap(c_q[3][Q_W]));
        mn    = (lo < hi) ? lo : hi;
        mx    = (lo < hi) ? hi : lo;
        enter = T_ZERO;
        leave = T_ONE;
        if (!f.a_zero) begin
            if (he > enter) enter = he;
            if (hl < leave) leave = hl;
        end
        if (f.v_en) begin
            if (mn > enter) enter = mn;
            if (mx < leave) leave = mx;
        end
        miss = f.h_miss || (f.a_zero && f.q_gt) || f.v_miss;
        n_out.hit        = !miss && (enter <= leave);
        n_out.enter_time = n_out.hit ? OUT_T_W'(enter) : OUT_T_W'(0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v) begin
            if (r_ov && i_stall) begin
                if (r_dv_v[Q_W-1]) begin
                    r_skid_v <= 1'b1;
                end
            end else begin
                r_ov <= r_dv_v[Q_W-1];
            end
        end else if (!i_stall) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            if (r_ov && i_stall) begin
                r_skid_d <= n_out;
            end else begin
                r_od <= n_out;
            end
        end else if (!i_stall) begin
            r_od <= r_skid_d;
        end
    end

    assign o_stall = r_skid_v;
    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule

// ===== rtl/sscc_sqrt_cell.sv =====
// sscc_sqrt_cell: one digit step of the integer square root, one root bit per cell
// depends on sscc_pkg
module sscc_sqrt_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [sscc_pkg::RAD_W-1:0]  i_rad,
    input  logic [sscc_pkg::REM_W-1:0]  i_rem,
    input  logic [sscc_pkg::ROOT_W-1:0] i_root,
    output logic [sscc_pkg::RAD_W-1:0]  o_rad,
    output logic [sscc_pkg::REM_W-1:0]  o_rem,
    output logic [sscc_pkg::ROOT_W-1:0] o_root
);
    import sscc_pkg::*;

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W+1:0]  n_cur;
    logic [REM_W+1:0]  n_trial;
    logic              n_ge;
    logic [RAD_W-1:0]  n_rad;
    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_root;

    always_comb begin
        // bring down the next two radicand bits, try root*4+1
        n_cur   = {i_rem, i_rad[RAD_W-1 -: 2]};
        n_trial = (REM_W + 2)'({i_root, 2'b01});
        n_ge    = n_cur >= n_trial;
        n_rem   = n_ge ? REM_W'(n_cur - n_trial) : REM_W'(n_cur);
        n_root  = {i_root[ROOT_W-2:0], n_ge};
        n_rad   = {i_rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ===== rtl/sscc_div_cell.sv =====
// sscc_div_cell: one restoring division step, one quotient bit per cell
// depends on sscc_pkg
module sscc_div_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [sscc_pkg::DIV_W-1:0] i_rem,
    input  logic [sscc_pkg::DIV_W-1:0] i_dsh,
    input  logic [sscc_pkg::Q_W-1:0]   i_q,
    output logic [sscc_pkg::DIV_W-1:0] o_rem,
    output logic [sscc_pkg::DIV_W-1:0] o_dsh,
    output logic [sscc_pkg::Q_W-1:0]   o_q
);
    import sscc_pkg::*;

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dsh;
    logic [Q_W-1:0]   r_q;
    logic             n_ge;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W-1:0] n_dsh;
    logic [Q_W-1:0]   n_q;

    always_comb begin
        n_ge  = i_rem >= i_dsh;
        n_rem = n_ge ? i_rem - i_dsh : i_rem;
        n_dsh = i_dsh >> 1;
        n_q   = {i_q[Q_W-2:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_dsh <= n_dsh;
            r_q   <= n_q;
        end
    end

    assign o_rem = r_rem;
    assign o_dsh = r_dsh;
    assign o_q   = r_q;

endmodule
